[sv/nmi_irq_timer_interrupt_unit_assert.svh]
// Assertion macros of the interrupt unit's RTL.
// No dependencies; included by nitu_core, which carries the concurrent assertions.
`ifndef NMI_IRQ_TIMER_INTERRUPT_UNIT_ASSERT_SVH
`define NMI_IRQ_TIMER_INTERRUPT_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define NITU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define NITU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/nitu_pkg.sv]
// Types and constants of the NMI and H/V timer IRQ interrupt unit.
// No dependencies; used by nitu_req_if and all modules of the unit.
package nitu_pkg;

    // Request kinds carried in req_type.
    typedef enum logic [2:0] {
        REQ_POLL      = 3'd0,
        REQ_WRITE     = 3'd1,
        REQ_NMI_READ  = 3'd2,
        REQ_TIMER_READ = 3'd3,
        REQ_NMI_TEST  = 3'd4,
        REQ_IRQ_TEST  = 3'd5
    } t_req_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_VDISP_LINE = 2'd0,
        CFG_VIRQ_LINE  = 2'd1,
        CFG_HIRQ_DOT   = 2'd2
    } t_cfg_idx;

    localparam int unsigned CFG_W   = 9;
    localparam int unsigned LINE_W  = 9;
    localparam int unsigned HCOUNT_W = 11;

    // Bit positions in the enable byte.
    localparam int unsigned EN_NMI_BIT  = 7;
    localparam int unsigned EN_VIRQ_BIT = 5;
    localparam int unsigned EN_HIRQ_BIT = 4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] VDISP_RESET = 9'd225;
    localparam logic [CFG_W-1:0] VIRQ_RESET  = 9'd511;
    localparam logic [CFG_W-1:0] HIRQ_RESET  = 9'd511;

    typedef struct packed {
        logic [CFG_W-1:0] vdisp_line;
        logic [CFG_W-1:0] virq_line;
        logic [CFG_W-1:0] hirq_dot;
    } t_cfg;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [LINE_W-1:0]   vcount_lag2;
        logic [LINE_W-1:0]   vcount_lag6;
        logic [LINE_W-1:0]   vcount_lag10;
        logic [HCOUNT_W-1:0] hcount_lag10;
        logic [7:0]          enable_byte;
        logic                irq_pin;
        logic                irq_mask_flag;
    } t_req_item;

    typedef struct packed {
        logic read_value;
        logic take_nmi;
        logic take_irq;
        logic wake_cpu;
        logic irq_locked;
    } t_result;

endpackage

[sv/nitu_req_if.sv]
// Request channel of the interrupt unit: valid/ready handshake and one request beat.
// Depends on nitu_pkg for the field widths.
interface nitu_req_if
    import nitu_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic [LINE_W-1:0]   vcount_lag2;
    logic [LINE_W-1:0]   vcount_lag6;
    logic [LINE_W-1:0]   vcount_lag10;
    logic [HCOUNT_W-1:0] hcount_lag10;
    logic [7:0]          enable_byte;
    logic                irq_pin;
    logic                irq_mask_flag;

    modport source (
        output valid, req_type, vcount_lag2, vcount_lag6, vcount_lag10,
               hcount_lag10, enable_byte, irq_pin, irq_mask_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, vcount_lag2, vcount_lag6, vcount_lag10,
               hcount_lag10, enable_byte, irq_pin, irq_mask_flag,
        output ready
    );
endinterface

[sv/nitu_rsp_if.sv]
// Result channel of the interrupt unit: valid/ready handshake and one result beat.
// No dependencies.
interface nitu_rsp_if;
    logic valid;
    logic ready;
    logic read_value;
    logic take_nmi;
    logic take_irq;
    logic wake_cpu;
    logic irq_locked;

    modport source (
        output valid, read_value, take_nmi, take_irq, wake_cpu, irq_locked,
        input  ready
    );
    modport sink (
        input  valid, read_value, take_nmi, take_irq, wake_cpu, irq_locked,
        output ready
    );
endinterface

[sv/nitu_cfg_regs.sv]
// Configuration registers of the interrupt unit: display height and timer targets.
// Depends on nitu_pkg.
module nitu_cfg_regs
    import nitu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vdisp_line <= VDISP_RESET;
            r_cfg.virq_line  <= VIRQ_RESET;
            r_cfg.hirq_dot   <= HIRQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VDISP_LINE: r_cfg.vdisp_line <= i_cfg_wdata;
                CFG_VIRQ_LINE:  r_cfg.virq_line  <= i_cfg_wdata;
                CFG_HIRQ_DOT:   r_cfg.hirq_dot   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/nitu_core.sv]
// Interrupt state of the unit: enables, NMI and timer IRQ lines, holds and pending flags.
// Depends on nitu_pkg and the assertion macros in nmi_irq_timer_interrupt_unit_assert.svh.
`include "nmi_irq_timer_interrupt_unit_assert.svh"

module nitu_core
    import nitu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_req_item i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    logic r_nmi_enable, r_vtimer_enable, r_htimer_enable;
    logic r_nmi_hold, r_nmi_valid, r_nmi_line, r_nmi_pending;
    logic r_irq_hold, r_irq_valid, r_irq_line, r_irq_pending;

    logic n_nmi_enable, n_vtimer_enable, n_htimer_enable;
    logic n_nmi_hold, n_nmi_valid, n_nmi_line, n_nmi_pending;
    logic n_irq_hold, n_irq_valid, n_irq_line, n_irq_pending;

    logic            nmi_level;
    logic            timer_match;
    logic            timer_any;
    logic [CFG_W+2:0] htarget;
    t_result         result;

    // Beam comparisons used by a poll tick.
    always_comb begin
        htarget   = {(i_cfg.hirq_dot + 9'd1) == 9'd0 ? 1'b1 : 1'b0,
                     i_cfg.hirq_dot + 9'd1, 2'b00};
        nmi_level = (i_item.vcount_lag2 >= i_cfg.vdisp_line);
        timer_any = r_vtimer_enable | r_htimer_enable;
        timer_match = timer_any;
        if ((r_vtimer_enable && (i_item.vcount_lag10 != i_cfg.virq_line)) ||
            (r_htimer_enable && ({1'b0, i_item.hcount_lag10} != htarget)) ||
            ((i_cfg.virq_line != '0) && (i_item.vcount_lag6 == '0))) begin
            timer_match = 1'b0;
        end
    end

    // Next state and result of the request in the input register.
    always_comb begin
        n_nmi_enable    = r_nmi_enable;
        n_vtimer_enable = r_vtimer_enable;
        n_htimer_enable = r_htimer_enable;
        n_nmi_hold      = r_nmi_hold;
        n_nmi_valid     = r_nmi_valid;
        n_nmi_line      = r_nmi_line;
        n_nmi_pending   = r_nmi_pending;
        n_irq_hold      = r_irq_hold;
        n_irq_valid     = r_irq_valid;
        n_irq_line      = r_irq_line;
        n_irq_pending   = r_irq_pending;
        result          = '0;

        case (i_item.req_type)
            REQ_POLL: begin
                // NMI edge against the start of vertical blank.
                if (r_nmi_hold) begin
                    n_nmi_hold = 1'b0;
                    if (r_nmi_enable) begin
                        n_nmi_pending = 1'b1;
                    end
                end
                if (!r_nmi_valid && nmi_level) begin
                    n_nmi_line = 1'b1;
                    n_nmi_hold = 1'b1;
                end else if (r_nmi_valid && !nmi_level) begin
                    n_nmi_line = 1'b0;
                end
                n_nmi_valid = nmi_level;
                // Timer IRQ edge.
                n_irq_hold = 1'b0;
                if (r_irq_line && timer_any) begin
                    n_irq_pending = 1'b1;
                end
                if (!r_irq_valid && timer_match) begin
                    n_irq_line = 1'b1;
                    n_irq_hold = 1'b1;
                end
                n_irq_valid = timer_match;
            end
            REQ_WRITE: begin
                n_nmi_enable    = i_item.enable_byte[EN_NMI_BIT];
                n_vtimer_enable = i_item.enable_byte[EN_VIRQ_BIT];
                n_htimer_enable = i_item.enable_byte[EN_HIRQ_BIT];
                if (!r_nmi_enable && n_nmi_enable && r_nmi_line) begin
                    n_nmi_pending = 1'b1;
                end
                if (n_vtimer_enable && !n_htimer_enable && r_irq_line) begin
                    n_irq_pending = 1'b1;
                end
                if (!n_vtimer_enable && !n_htimer_enable) begin
                    n_irq_line    = 1'b0;
                    n_irq_pending = 1'b0;
                end
                result.irq_locked = 1'b1;
            end
            REQ_NMI_READ: begin
                result.read_value = r_nmi_line;
                if (!r_nmi_hold) begin
                    n_nmi_line = 1'b0;
                end
            end
            REQ_TIMER_READ: begin
                result.read_value = r_irq_line;
                if (!r_irq_hold) begin
                    n_irq_line    = 1'b0;
                    n_irq_pending = 1'b0;
                end
            end
            REQ_NMI_TEST: begin
                if (r_nmi_pending) begin
                    n_nmi_pending   = 1'b0;
                    result.take_nmi = 1'b1;
                    result.wake_cpu = 1'b1;
                end
            end
            REQ_IRQ_TEST: begin
                if (r_irq_pending || i_item.irq_pin) begin
                    n_irq_pending   = 1'b0;
                    result.wake_cpu = 1'b1;
                    result.take_irq = !i_item.irq_mask_flag;
                end
            end
            default: ;
        endcase
    end

    // State update on each request that moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nmi_enable    <= 1'b0;
            r_vtimer_enable <= 1'b0;
            r_htimer_enable <= 1'b0;
            r_nmi_hold      <= 1'b0;
            r_nmi_valid     <= 1'b0;
            r_nmi_line      <= 1'b0;
            r_nmi_pending   <= 1'b0;
            r_irq_hold      <= 1'b0;
            r_irq_valid     <= 1'b0;
            r_irq_line      <= 1'b0;
            r_irq_pending   <= 1'b0;
        end else if (i_fire) begin
            r_nmi_enable    <= n_nmi_enable;
            r_vtimer_enable <= n_vtimer_enable;
            r_htimer_enable <= n_htimer_enable;
            r_nmi_hold      <= n_nmi_hold;
            r_nmi_valid     <= n_nmi_valid;
            r_nmi_line      <= n_nmi_line;
            r_nmi_pending   <= n_nmi_pending;
            r_irq_hold      <= n_irq_hold;
            r_irq_valid     <= n_irq_valid;
            r_irq_line      <= n_irq_line;
            r_irq_pending   <= n_irq_pending;
        end
    end

    assign o_result = result;

    // An NMI hold only lasts while the line it raised is still up.
    `NITU_ASSERT(a_nmi_hold_line, i_clk, i_rst_n, r_nmi_hold |-> (r_nmi_line && r_nmi_valid),
        "NMI hold set without an active NMI line")
    // A timer hold is only set together with a valid match.
    `NITU_ASSERT(a_irq_hold_valid, i_clk, i_rst_n, r_irq_hold |-> r_irq_valid,
        "timer IRQ hold set without a valid match")
    // Disabling both timers drops the timer line and its pending flag.
    `NITU_ASSERT(a_timer_off_clears, i_clk, i_rst_n,
        (i_fire && (i_item.req_type == REQ_WRITE) &&
         !i_item.enable_byte[EN_VIRQ_BIT] && !i_item.enable_byte[EN_HIRQ_BIT])
        |=> (!r_irq_line && !r_irq_pending),
        "timer IRQ still pending after both timers were disabled")
    // Reset leaves every line and pending flag low.
    `NITU_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (!r_nmi_line && !r_nmi_pending && !r_irq_line && !r_irq_pending),
        "interrupt state not cleared by reset")

endmodule

[sv/nmi_irq_timer_interrupt_unit.sv]
// Top level of the NMI and H/V timer IRQ interrupt unit: request and result registers.
// Depends on nitu_pkg, nitu_req_if, nitu_rsp_if, nitu_cfg_regs and nitu_core.

// The unit gives exactly one result beat for each request beat: the request is captured
// in an input register, the result is formed from it in combinational logic while the
// interrupt state is updated, and the result waits in an output register until it is
// taken. A new request is accepted while a finished result is still waiting, so the
// sustained rate is one beat per clock as long as the result side keeps taking beats.
// Configuration writes take effect on the following clock and are meant to happen while
// no request is in flight.
module nmi_irq_timer_interrupt_unit
    import nitu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    nitu_req_if.sink         i_req,
    nitu_rsp_if.source       o_rsp
);

    t_cfg      cfg;
    t_req_item r_item;
    logic      r_item_valid;
    t_result   r_result;
    logic      r_result_valid;
    t_result   result;
    logic      advance;
    logic      accept;

    nitu_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    nitu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held request moves on when the result register is free or being emptied.
    assign advance     = r_item_valid && (!r_result_valid || o_rsp.ready);
    assign i_req.ready = !r_item_valid || advance;
    assign accept      = i_req.valid && i_req.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (accept) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req_type      <= i_req.req_type;
            r_item.vcount_lag2   <= i_req.vcount_lag2;
            r_item.vcount_lag6   <= i_req.vcount_lag6;
            r_item.vcount_lag10  <= i_req.vcount_lag10;
            r_item.hcount_lag10  <= i_req.hcount_lag10;
            r_item.enable_byte   <= i_req.enable_byte;
            r_item.irq_pin       <= i_req.irq_pin;
            r_item.irq_mask_flag <= i_req.irq_mask_flag;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (advance) begin
            r_result_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_rsp.valid      = r_result_valid;
    assign o_rsp.read_value = r_result.read_value;
    assign o_rsp.take_nmi   = r_result.take_nmi;
    assign o_rsp.take_irq   = r_result.take_irq;
    assign o_rsp.wake_cpu   = r_result.wake_cpu;
    assign o_rsp.irq_locked = r_result.irq_locked;

endmodule
